@@ rtl/hva_pkg.sv @@
// Shared constants, opcodes and controller-to-datapath command type.
package hva_pkg;

    // Channel width and derived datapath widths
    localparam int CHAN_BITS = 8;
    localparam int PROD_W    = 2 * CHAN_BITS;        // distance times range span
    localparam int NUM_W     = PROD_W + CHAN_BITS;   // scaled by full-scale value
    localparam int REM_W     = NUM_W + 2;            // rounded dividend
    localparam int DEN_W     = PROD_W + 1;           // doubled divisor
    localparam int CNT_W     = $clog2(CHAN_BITS);    // divider step counter

    localparam logic [CHAN_BITS-1:0] CHAN_MAX = '1;

    // Item opcodes
    localparam logic [1:0] OP_CLEAR   = 2'd0;
    localparam logic [1:0] OP_MEASURE = 2'd1;
    localparam logic [1:0] OP_APPLY   = 2'd2;

    // Commands from controller to datapath
    typedef struct packed {
        logic clear;    // reset measured range
        logic measure;  // fold pixel value into range
        logic load;     // capture apply pixel
        logic mul;      // form numerators and denominator
        logic prep;     // load divider lanes
        logic step;     // one restoring divide step
        logic fin;      // load result register
    } t_cmd;

endpackage

@@ rtl/hva_in_if.sv @@
// Input item channel: opcode and RGBA pixel with valid/ready handshake.
interface hva_in_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     op;
    logic [hva_pkg::CHAN_BITS-1:0]  red;
    logic [hva_pkg::CHAN_BITS-1:0]  green;
    logic [hva_pkg::CHAN_BITS-1:0]  blue;
    logic [hva_pkg::CHAN_BITS-1:0]  alpha;

    modport source (output valid, op, red, green, blue, alpha, input ready);
    modport sink   (input valid, op, red, green, blue, alpha, output ready);
endinterface

@@ rtl/hva_out_if.sv @@
// Result item channel: stretched RGBA pixel with valid/ready handshake.
interface hva_out_if;
    logic                           valid;
    logic                           ready;
    logic [hva_pkg::CHAN_BITS-1:0]  red_out;
    logic [hva_pkg::CHAN_BITS-1:0]  green_out;
    logic [hva_pkg::CHAN_BITS-1:0]  blue_out;
    logic [hva_pkg::CHAN_BITS-1:0]  alpha_out;

    modport source (output valid, red_out, green_out, blue_out, alpha_out, input ready);
    modport sink   (input valid, red_out, green_out, blue_out, alpha_out, output ready);
endinterface

@@ rtl/hva_dp.sv @@
// Datapath: range registers, multipliers, three divider lanes, result register.
module hva_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  hva_pkg::t_cmd                  i_cmd,
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_wdata,
    input  logic [hva_pkg::CHAN_BITS-1:0]  i_red,
    input  logic [hva_pkg::CHAN_BITS-1:0]  i_green,
    input  logic [hva_pkg::CHAN_BITS-1:0]  i_blue,
    input  logic [hva_pkg::CHAN_BITS-1:0]  i_alpha,
    output logic [hva_pkg::CHAN_BITS-1:0]  o_red_out,
    output logic [hva_pkg::CHAN_BITS-1:0]  o_green_out,
    output logic [hva_pkg::CHAN_BITS-1:0]  o_blue_out,
    output logic [hva_pkg::CHAN_BITS-1:0]  o_alpha_out
);

    localparam int CB = hva_pkg::CHAN_BITS;

    // Configuration and measured range
    logic          r_use_alpha;
    logic [CB-1:0] r_lo;
    logic [CB-1:0] r_hi;

    // Captured apply pixel
    logic [CB-1:0] r_ch    [3];
    logic [CB-1:0] r_d     [3];
    logic [CB-1:0] r_alpha;
    logic [CB-1:0] r_mx;
    logic [CB-1:0] r_v;

    // Products and case flags
    logic [hva_pkg::NUM_W-1:0] r_num  [3];
    logic [hva_pkg::PROD_W-1:0] r_den;
    logic          r_bypass;
    logic [2:0]    r_zero;

    // Divider lanes
    logic [hva_pkg::REM_W-1:0] r_rem [3];
    logic [hva_pkg::REM_W-1:0] r_dsh;
    logic [CB-1:0]             r_quo [3];
    logic [2:0]                r_ovf;

    // Result register
    logic [CB-1:0] r_out [3];
    logic [CB-1:0] r_alpha_out;

    // Input pixel: max channel, distances to it, largest distance
    logic [CB-1:0] in_ch [3];
    logic [CB-1:0] in_mx;
    logic [CB-1:0] in_d  [3];
    logic [CB-1:0] in_v;

    always_comb begin
        in_ch[0] = i_red;
        in_ch[1] = i_green;
        in_ch[2] = i_blue;
        in_mx = in_ch[0];
        if (in_ch[1] > in_mx) in_mx = in_ch[1];
        if (in_ch[2] > in_mx) in_mx = in_ch[2];
        for (int i = 0; i < 3; i++) begin
            in_d[i] = in_mx - in_ch[i];
        end
        in_v = in_d[0];
        if (in_d[1] > in_v) in_v = in_d[1];
        if (in_d[2] > in_v) in_v = in_d[2];
    end

    // Signed spans of the mapping, as sign and magnitude
    logic          num_neg;
    logic          den_neg;
    logic [CB-1:0] num_mag;
    logic [CB-1:0] den_mag;

    always_comb begin
        num_neg = r_v < r_lo;
        den_neg = r_hi < r_lo;
        num_mag = num_neg ? (r_lo - r_v) : (r_v - r_lo);
        den_mag = den_neg ? (r_lo - r_hi) : (r_hi - r_lo);
    end

    // Rounded dividend and doubled divisor per lane
    logic [hva_pkg::REM_W-1:0] prep_n [3];
    logic [hva_pkg::DEN_W-1:0] prep_d2;

    always_comb begin
        prep_d2 = {r_den, 1'b0};
        for (int i = 0; i < 3; i++) begin
            prep_n[i] = hva_pkg::REM_W'({r_num[i], 1'b0}) + hva_pkg::REM_W'(r_den);
        end
    end

    // Final distance and channel value per lane
    logic [CB-1:0] fin_dn  [3];
    logic [CB-1:0] fin_out [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_zero[i]) begin
                fin_dn[i] = '0;
            end else if (r_ovf[i]) begin
                fin_dn[i] = hva_pkg::CHAN_MAX;
            end else begin
                fin_dn[i] = r_quo[i];
            end
            if (r_bypass) begin
                fin_out[i] = r_ch[i];
            end else if (fin_dn[i] >= r_mx) begin
                fin_out[i] = '0;
            end else begin
                fin_out[i] = r_mx - fin_dn[i];
            end
        end
    end

    // Configuration and range state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_alpha <= 1'b0;
            r_lo        <= hva_pkg::CHAN_MAX;
            r_hi        <= '0;
        end else begin
            if (i_cfg_we) begin
                r_use_alpha <= i_cfg_wdata;
            end
            if (i_cmd.clear) begin
                r_lo <= hva_pkg::CHAN_MAX;
                r_hi <= '0;
            end else if (i_cmd.measure && (!r_use_alpha || i_alpha != '0)) begin
                if (in_v > r_hi) r_hi <= in_v;
                if (in_v < r_lo) r_lo <= in_v;
            end
        end
    end

    // Payload pipeline: capture, multiply, divide, result
    always_ff @(posedge i_clk) begin
        logic [hva_pkg::PROD_W-1:0] prod;
        if (i_cmd.load) begin
            for (int i = 0; i < 3; i++) begin
                r_ch[i] <= in_ch[i];
                r_d[i]  <= in_d[i];
            end
            r_alpha <= i_alpha;
            r_mx    <= in_mx;
            r_v     <= in_v;
        end
        if (i_cmd.mul) begin
            for (int i = 0; i < 3; i++) begin
                prod = hva_pkg::PROD_W'(r_d[i]) * hva_pkg::PROD_W'(num_mag);
                // times full scale: shift and subtract
                r_num[i]  <= (hva_pkg::NUM_W'(prod) << CB) - hva_pkg::NUM_W'(prod);
                r_zero[i] <= (r_d[i] == '0) || (num_mag == '0) || (num_neg != den_neg);
            end
            r_den    <= hva_pkg::PROD_W'(r_v) * hva_pkg::PROD_W'(den_mag);
            r_bypass <= (r_hi == r_lo) || (r_v == '0);
        end
        if (i_cmd.prep) begin
            for (int i = 0; i < 3; i++) begin
                r_rem[i] <= prep_n[i];
                r_quo[i] <= '0;
                // quotient would not fit in one channel: clamp
                r_ovf[i] <= prep_n[i] >= (hva_pkg::REM_W'(prep_d2) << CB);
            end
            r_dsh <= hva_pkg::REM_W'(prep_d2) << (CB - 1);
        end
        if (i_cmd.step) begin
            for (int i = 0; i < 3; i++) begin
                if (r_rem[i] >= r_dsh) begin
                    r_rem[i] <= r_rem[i] - r_dsh;
                    r_quo[i] <= {r_quo[i][CB-2:0], 1'b1};
                end else begin
                    r_quo[i] <= {r_quo[i][CB-2:0], 1'b0};
                end
            end
            r_dsh <= r_dsh >> 1;
        end
        if (i_cmd.fin) begin
            for (int i = 0; i < 3; i++) begin
                r_out[i] <= fin_out[i];
            end
            r_alpha_out <= r_alpha;
        end
    end

    assign o_red_out   = r_out[0];
    assign o_green_out = r_out[1];
    assign o_blue_out  = r_out[2];
    assign o_alpha_out = r_alpha_out;

endmodule

@@ rtl/hva_ctrl.sv @@
// Controller: sequences apply items through multiply, divide and result load.
module hva_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic [1:0]    i_in_op,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output hva_pkg::t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_PREP,
        S_DIV,
        S_FIN
    } t_state;

    t_state                     r_state;
    logic [hva_pkg::CNT_W-1:0]  r_cnt;
    logic                       r_out_valid;
    logic                       in_fire;
    logic                       out_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    // Decode commands
    always_comb begin
        o_cmd         = '0;
        o_cmd.clear   = in_fire && (i_in_op == hva_pkg::OP_CLEAR);
        o_cmd.measure = in_fire && (i_in_op == hva_pkg::OP_MEASURE);
        o_cmd.load    = in_fire && (i_in_op == hva_pkg::OP_APPLY);
        o_cmd.mul     = (r_state == S_MUL);
        o_cmd.prep    = (r_state == S_PREP);
        o_cmd.step    = (r_state == S_DIV);
        o_cmd.fin     = (r_state == S_FIN) && out_free;
    end

    // State, step counter and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.fin) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_cmd.load) r_state <= S_MUL;
                end
                S_MUL: begin
                    r_state <= S_PREP;
                end
                S_PREP: begin
                    r_cnt   <= hva_pkg::CNT_W'(hva_pkg::CHAN_BITS - 1);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_cnt == '0) begin
                        r_state <= S_FIN;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                S_FIN: begin
                    if (out_free) r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // An apply item blocks further input until its result is loaded
    a_apply_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_in_op == hva_pkg::OP_APPLY) |=> !o_in_ready)
        else $error("input still ready after apply item");

    // A result appears only from the load state
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_FIN)
        else $error("result valid without a finished apply item");

    // Clear and measure items leave the controller idle
    a_short_ops_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_in_op != hva_pkg::OP_APPLY) |=> (r_state == S_IDLE))
        else $error("non-apply item started a sequence");

    // The divider runs its full step count before the result load
    a_div_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && $past(r_state) == S_DIV) |-> $past(r_cnt) == '0)
        else $error("divider left early");

endmodule

@@ rtl/hsv_value_autostretch.sv @@
// Apply items: result valid after result load; next item can be taken in the same cycle.
// Clear/measure items: one per cycle when idle, no result, range updated at acceptance.
// Apply items hold input until their result load and pass the 8-step restoring divider
// (three lanes, one per channel) after acceptance, multiply and divider load.
// Reset is synchronous, active low: range low 255, range high 0, use_alpha 0, no result.
module hsv_value_autostretch (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hva_in_if.sink      i_in,
    hva_out_if.source   o_out,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata
);

    hva_pkg::t_cmd cmd;

    // Sequencing
    hva_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_op     (i_in.op),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd)
    );

    // Arithmetic and state
    hva_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_red       (i_in.red),
        .i_green     (i_in.green),
        .i_blue      (i_in.blue),
        .i_alpha     (i_in.alpha),
        .o_red_out   (o_out.red_out),
        .o_green_out (o_out.green_out),
        .o_blue_out  (o_out.blue_out),
        .o_alpha_out (o_out.alpha_out)
    );

endmodule

@@ bench/testbench.sv @@
// Self-checking bench for the value autostretch block: directed table, random frames, predictor.
`timescale 1ns / 100ps

module testbench;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         RANDOM_ITEMS = 1350;
    localparam int         DRAIN_CYCLES = 12;     // apply latency plus margin
    localparam int         STALL_LIMIT  = 4000;   // cycles with no transfer at all

    typedef struct packed {
        logic [1:0]                    op;
        logic [hva_pkg::CHAN_BITS-1:0] red;
        logic [hva_pkg::CHAN_BITS-1:0] green;
        logic [hva_pkg::CHAN_BITS-1:0] blue;
        logic [hva_pkg::CHAN_BITS-1:0] alpha;
    } t_pix_in;

    typedef struct packed {
        logic [hva_pkg::CHAN_BITS-1:0] red;
        logic [hva_pkg::CHAN_BITS-1:0] green;
        logic [hva_pkg::CHAN_BITS-1:0] blue;
        logic [hva_pkg::CHAN_BITS-1:0] alpha;
    } t_pixel;

    typedef struct packed {
        logic    cfg_wr;      // write use_alpha before this item
        logic    cfg_val;
        t_pix_in item;
        logic    golden_ok;   // expected pixel typed in below
        t_pixel  golden;
    } t_plan_row;

    localparam int PLAN_LEN = 25;
    localparam t_plan_row PLAN [PLAN_LEN] = '{
        // after reset: grey pixels pass through
        '{1'b0, 1'b0, '{hva_pkg::OP_APPLY, 8'd0, 8'd0, 8'd0, 8'd0}, 1'b1,
          '{8'd0, 8'd0, 8'd0, 8'd0}},
        '{1'b0, 1'b0, '{hva_pkg::OP_APPLY, 8'd255, 8'd255, 8'd255, 8'd255}, 1'b1,
          '{8'd255, 8'd255, 8'd255, 8'd255}},
        // after reset: inverted range used as it stands
        '{1'b0, 1'b0, '{hva_pkg::OP_APPLY, 8'd200, 8'd100, 8'd50, 8'd3}, 1'b0, '0},
        '{1'b0, 1'b0, '{hva_pkg::OP_APPLY, 8'd255, 8'd0, 8'd0, 8'd255}, 1'b0, '0},
        // unused opcode: nothing happens
        '{1'b0, 1'b0, '{OP_UNUSED, 8'd170, 8'd85, 8'd255, 8'd0}, 1'b0, '0},
        // single grey measure: low equals high, apply passes through
        '{1'b0, 1'b0, '{hva_pkg::OP_MEASURE, 8'd255, 8'd255, 8'd255, 8'd0}, 1'b0, '0},
        '{1'b0, 1'b0, '{hva_pkg::OP_APPLY, 8'd100, 8'd50, 8'd0, 8'd9}, 1'b1,
          '{8'd100, 8'd50, 8'd0, 8'd9}},
        // full range 0..255
        '{1'b0, 1'b0, '{hva_pkg::OP_MEASURE, 8'd255, 8'd0, 8'd0, 8'd128}, 1'b0, '0},
        '{1'b0, 1'b0, '{hva_pkg::OP_APPLY, 8'd255, 8'd0, 8'd0, 8'd170}, 1'b0, '0},
        '{1'b0, 1'b0, '{hva_pkg::OP_APPLY, 8'd0, 8'd255, 8'd128, 8'd85}, 1'b0, '0},
        '{1'b0, 1'b0, '{hva_pkg::OP_APPLY, 8'd1, 8'd0, 8'd0, 8'd1}, 1'b0, '0},
        // range 30..100: at low, above high (clamp), below low
        '{1'b0, 1'b0, '{hva_pkg::OP_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0}, 1'b0, '0},
        '{1'b0, 1'b0, '{hva_pkg::OP_MEASURE, 8'd40, 8'd20, 8'd10, 8'd60}, 1'b0, '0},
        '{1'b0, 1'b0, '{hva_pkg::OP_MEASURE, 8'd100, 8'd0, 8'd50, 8'd255}, 1'b0, '0},
        '{1'b0, 1'b0, '{hva_pkg::OP_APPLY, 8'd60, 8'd30, 8'd45, 8'd200}, 1'b0, '0},
        '{1'b0, 1'b0, '{hva_pkg::OP_APPLY, 8'd200, 8'd0, 8'd0, 8'd17}, 1'b0, '0},
        '{1'b0, 1'b0, '{hva_pkg::OP_APPLY, 8'd10, 8'd5, 8'd0, 8'd33}, 1'b0, '0},
        // apply right after clear
        '{1'b0, 1'b0, '{hva_pkg::OP_CLEAR, 8'd85, 8'd170, 8'd85, 8'd170}, 1'b0, '0},
        '{1'b0, 1'b0, '{hva_pkg::OP_APPLY, 8'd100, 8'd90, 8'd95, 8'd240}, 1'b0, '0},
        // alpha gating on: transparent measure is skipped
        '{1'b1, 1'b1, '{hva_pkg::OP_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0}, 1'b0, '0},
        '{1'b0, 1'b0, '{hva_pkg::OP_MEASURE, 8'd255, 8'd0, 8'd0, 8'd0}, 1'b0, '0},
        '{1'b0, 1'b0, '{hva_pkg::OP_MEASURE, 8'd50, 8'd20, 8'd40, 8'd255}, 1'b0, '0},
        '{1'b0, 1'b0, '{hva_pkg::OP_MEASURE, 8'd90, 8'd10, 8'd30, 8'd1}, 1'b0, '0},
        '{1'b0, 1'b0, '{hva_pkg::OP_APPLY, 8'd255, 8'd0, 8'd0, 8'd0}, 1'b0, '0},
        '{1'b0, 1'b0, '{hva_pkg::OP_APPLY, 8'd0, 8'd128, 8'd64, 8'd254}, 1'b0, '0}
    };

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    hva_in_if  pix_in ();
    hva_out_if pix_out ();

    hsv_value_autostretch i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in        (pix_in),
        .o_out       (pix_out),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    // Predictor state
    logic [hva_pkg::CHAN_BITS-1:0] span_lo = hva_pkg::CHAN_MAX;
    logic [hva_pkg::CHAN_BITS-1:0] span_hi = '0;
    bit                            alpha_gate = 1'b0;

    t_pixel expected_px [$];
    int     mismatches = 0;
    int     sent_items = 0;
    int     stall_cycles = 0;
    bit     steady = 1'b0;

    // Clock
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [hva_pkg::CHAN_BITS-1:0] peak_of(t_pix_in it);
        logic [hva_pkg::CHAN_BITS-1:0] m;
        m = it.red;
        if (it.green > m) m = it.green;
        if (it.blue > m) m = it.blue;
        return m;
    endfunction

    // Largest distance of a channel below the peak
    function automatic logic [hva_pkg::CHAN_BITS-1:0] spread_of(t_pix_in it);
        logic [hva_pkg::CHAN_BITS-1:0] pk;
        logic [hva_pkg::CHAN_BITS-1:0] m;
        pk = peak_of(it);
        m = pk - it.red;
        if (pk - it.green > m) m = pk - it.green;
        if (pk - it.blue > m) m = pk - it.blue;
        return m;
    endfunction

    // Rescale each channel distance so the spread maps from [lo, hi] onto full scale
    function automatic t_pixel stretch_pixel(t_pix_in it);
        logic [hva_pkg::CHAN_BITS-1:0] chan [3];
        logic [hva_pkg::CHAN_BITS-1:0] res_ch [3];
        logic [hva_pkg::CHAN_BITS-1:0] pk;
        logic [hva_pkg::CHAN_BITS-1:0] spread;
        longint unsigned               gap, num_mag, den_mag, num, den, q;
        bit                            num_neg, den_neg;
        t_pixel                        res;
        chan[0] = it.red;
        chan[1] = it.green;
        chan[2] = it.blue;
        pk      = peak_of(it);
        spread  = spread_of(it);
        num_neg = spread < span_lo;
        den_neg = span_hi < span_lo;
        num_mag = num_neg ? longint'(span_lo - spread) : longint'(spread - span_lo);
        den_mag = den_neg ? longint'(span_lo - span_hi) : longint'(span_hi - span_lo);
        for (int i = 0; i < 3; i++) begin
            res_ch[i] = chan[i];
            if (span_hi != span_lo && spread != 0) begin
                gap = longint'(pk - chan[i]);
                num = gap * num_mag * 64'd255;
                den = longint'(spread) * den_mag;
                if (den == 0) begin
                    q = gap;
                end else if (num == 0 || num_neg != den_neg) begin
                    q = 0;
                end else begin
                    q = (2 * num + den) / (2 * den);
                    if (q > 255) q = 255;
                end
                res_ch[i] = (q >= longint'(pk)) ? '0 : pk - q[hva_pkg::CHAN_BITS-1:0];
            end
        end
        res.red   = res_ch[0];
        res.green = res_ch[1];
        res.blue  = res_ch[2];
        res.alpha = it.alpha;
        return res;
    endfunction

    // Advance predictor state for one accepted item
    task automatic predict_item(input t_pix_in it, input bit golden_ok, input t_pixel golden);
        logic [hva_pkg::CHAN_BITS-1:0] spread;
        spread = spread_of(it);
        case (it.op)
            hva_pkg::OP_CLEAR: begin
                span_lo = hva_pkg::CHAN_MAX;
                span_hi = '0;
            end
            hva_pkg::OP_MEASURE: begin
                if (!alpha_gate || it.alpha != 0) begin
                    if (spread > span_hi) span_hi = spread;
                    if (spread < span_lo) span_lo = spread;
                end
            end
            hva_pkg::OP_APPLY: begin
                expected_px.push_back(golden_ok ? golden : stretch_pixel(it));
            end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= 50)
            $display("mismatch @%0t: %s got %0d want %0d", $time, what, got, want);
    endtask

    // Present one item, hold until accepted, then predict it
    task automatic send_item(input t_pix_in it, input bit golden_ok, input t_pixel golden);
        if (!steady) begin
            while ($urandom_range(0, 99) < 32) begin
                pix_in.valid <= 1'b0;
                @(posedge clk);
            end
        end
        pix_in.valid <= 1'b1;
        pix_in.op    <= it.op;
        pix_in.red   <= it.red;
        pix_in.green <= it.green;
        pix_in.blue  <= it.blue;
        pix_in.alpha <= it.alpha;
        @(posedge clk);
        while (!pix_in.ready) @(posedge clk);
        predict_item(it, golden_ok, golden);
        if (it.op != OP_UNUSED) sent_items++;
    endtask

    // Drop valid and wait for all pending pixels plus the apply latency
    task automatic drain_pixels();
        pix_in.valid <= 1'b0;
        @(posedge clk);
        while (expected_px.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_use_alpha(input bit val);
        drain_pixels();
        cfg_we    <= 1'b1;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we     <= 1'b0;
        alpha_gate = val;
    endtask

    function automatic logic [hva_pkg::CHAN_BITS-1:0] pick_channel();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return hva_pkg::CHAN_MAX;
            default: return hva_pkg::CHAN_BITS'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic t_pix_in rand_pixel(input logic [1:0] op);
        t_pix_in it;
        it.op    = op;
        it.red   = pick_channel();
        it.green = pick_channel();
        it.blue  = pick_channel();
        if ($urandom_range(0, 9) == 0) begin
            it.green = it.red;
            it.blue  = it.red;
        end
        it.alpha = ($urandom_range(0, 3) == 0) ? '0 : pick_channel();
        return it;
    endfunction

    // Stimulus
    initial begin
        t_pix_in base;
        t_pix_in it;
        int      n_meas;
        int      n_apply;
        bit      same_px;
        rst_n        <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_wdata    <= 1'b0;
        pix_in.valid <= 1'b0;
        pix_in.op    <= hva_pkg::OP_CLEAR;
        pix_in.red   <= '0;
        pix_in.green <= '0;
        pix_in.blue  <= '0;
        pix_in.alpha <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        for (int k = 0; k < PLAN_LEN; k++) begin
            if (PLAN[k].cfg_wr) write_use_alpha(PLAN[k].cfg_val);
            send_item(PLAN[k].item, PLAN[k].golden_ok, PLAN[k].golden);
        end
        write_use_alpha(1'b0);
        sent_items = 0;

        // Random frames: clear, measure a few pixels, apply a few
        while (sent_items < RANDOM_ITEMS) begin
            steady = (sent_items >= 500 && sent_items < 700);
            if ($urandom_range(0, 3) == 0) write_use_alpha(1'($urandom_range(0, 1)));
            if ($urandom_range(0, 9) != 0) send_item(rand_pixel(hva_pkg::OP_CLEAR), 1'b0, '0);
            same_px = ($urandom_range(0, 9) == 0);
            base    = rand_pixel(hva_pkg::OP_MEASURE);
            n_meas  = $urandom_range(0, 10);
            for (int i = 0; i < n_meas; i++) begin
                it = same_px ? base : rand_pixel(hva_pkg::OP_MEASURE);
                if ($urandom_range(0, 29) == 0) it.op = OP_UNUSED;
                send_item(it, 1'b0, '0);
            end
            n_apply = $urandom_range(1, 10);
            for (int i = 0; i < n_apply; i++) begin
                it = rand_pixel(hva_pkg::OP_APPLY);
                if ($urandom_range(0, 19) == 0) it.op = hva_pkg::OP_MEASURE;
                else if ($urandom_range(0, 29) == 0) it.op = OP_UNUSED;
                send_item(it, 1'b0, '0);
            end
        end
        steady = 1'b0;

        drain_pixels();
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Result sink: random backpressure, none during the steady stretch
    always @(posedge clk) begin
        pix_out.ready <= steady || ($urandom_range(0, 99) >= 32);
    end

    // Compare each accepted pixel with the oldest expectation
    always @(posedge clk) begin : check_pixels
        t_pixel want;
        if (rst_n && pix_out.valid && pix_out.ready) begin
            if (expected_px.size() == 0) begin
                report_mismatch("unexpected pixel, red", int'(pix_out.red_out), -1);
            end else begin
                want = expected_px.pop_front();
                if (pix_out.red_out !== want.red)
                    report_mismatch("red_out", int'(pix_out.red_out), int'(want.red));
                if (pix_out.green_out !== want.green)
                    report_mismatch("green_out", int'(pix_out.green_out), int'(want.green));
                if (pix_out.blue_out !== want.blue)
                    report_mismatch("blue_out", int'(pix_out.blue_out), int'(want.blue));
                if (pix_out.alpha_out !== want.alpha)
                    report_mismatch("alpha_out", int'(pix_out.alpha_out), int'(want.alpha));
            end
        end
    end

    // Watchdog: end the run if nothing moves for too long
    always @(posedge clk) begin
        if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready) || cfg_we)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

endmodule
